FILE: rtl/polyline_arc_length_projection_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the polyline arc length projection block.
// ----------------------------------------------------------------------------
`ifndef POLYLINE_ARC_LENGTH_PROJECTION_MACROS_SVH
`define POLYLINE_ARC_LENGTH_PROJECTION_MACROS_SVH

// Same-cycle implication, sampled on clk and quiet during reset.
`define PALP_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and quiet during reset.
`define PALP_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/palp_pkg.sv
// ----------------------------------------------------------------------------
// palp_pkg
// Shared codes and types of the polyline arc length projection block.
// ----------------------------------------------------------------------------
`default_nettype none

package palp_pkg;

	// Request codes carried by req_type.
	localparam logic [1:0] REQ_CLEAR  = 2'd0;
	localparam logic [1:0] REQ_APPEND = 2'd1;
	localparam logic [1:0] REQ_QUERY  = 2'd2;

	// Result status codes.
	localparam logic [1:0] ST_PROJECTED = 2'd0;
	localparam logic [1:0] ST_VERTEX    = 2'd1;
	localparam logic [1:0] ST_TOO_FEW   = 2'd2;

	// Register indexes, decoded from paddr[2].
	localparam logic REG_LINE_CLOSED = 1'b0;
	localparam logic REG_EPSILON_SQ  = 1'b1;

	// Reset value of the minimum squared segment length.
	localparam logic [31:0] EPS_RESET = 32'd4295;

	typedef logic signed [31:0] coord_t;
	typedef logic signed [32:0] diff_t;
	typedef logic signed [67:0] wide_t;

endpackage

`default_nettype wire

FILE: rtl/polyline_arc_length_projection.sv
// ----------------------------------------------------------------------------
// polyline_arc_length_projection
// Stores a 3D polyline and projects query points onto it by arc length.
// ----------------------------------------------------------------------------
// Usage: input beats (req_type, coord_x/y/z) arrive on in_valid/in_ready.
// A clear or append beat gives no result; a query beat gives one result beat
// on out_valid/out_ready. Registers line_closed (0x0) and epsilon_sq (0x4)
// are to be written over the APB port while the block is idle; the block
// itself does not enforce this. One item is in work at a time; in_ready is
// high only in the idle state. An append makes two passes of a dot product
// and a 34-step square root. A query scans every stored vertex through the
// shared multiplier, then makes up to two segment tests and, for a
// projection, four serial divisions. All arithmetic goes through one
// multiplier, one square root stepper and one divider stepper under a
// single sequencer. A finished result sits in the output register; the block
// takes the next beat while it waits, but a later query holds in its final
// state until the receiver takes the previous result. Reset empties the
// line and restores the registers; the vertex memories are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module polyline_arc_length_projection
	import palp_pkg::*;
#(
	parameter int MAX_POINTS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  coord_t      coord_x,
	input  coord_t      coord_y,
	input  coord_t      coord_z,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [31:0] coverage,
	output coord_t      proj_x,
	output coord_t      proj_y,
	output coord_t      proj_z,
	output logic [9:0]  nearest_index
);

	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);

	// Sequencer states.
	localparam logic [4:0] S_IDLE     = 5'd0;
	localparam logic [4:0] S_WAIT     = 5'd1;
	localparam logic [4:0] S_DOT      = 5'd2;
	localparam logic [4:0] S_SQRT     = 5'd3;
	localparam logic [4:0] S_APP_LD   = 5'd4;
	localparam logic [4:0] S_APP_SQ   = 5'd5;
	localparam logic [4:0] S_APP_CUM  = 5'd6;
	localparam logic [4:0] S_APP_TOT  = 5'd7;
	localparam logic [4:0] S_Q_START  = 5'd8;
	localparam logic [4:0] S_SCAN_LD  = 5'd9;
	localparam logic [4:0] S_SCAN_CMP = 5'd10;
	localparam logic [4:0] S_K_START  = 5'd11;
	localparam logic [4:0] S_K_LD     = 5'd12;
	localparam logic [4:0] S_K_D      = 5'd13;
	localparam logic [4:0] S_K_N      = 5'd14;
	localparam logic [4:0] S_DIV_SET  = 5'd15;
	localparam logic [4:0] S_DIV      = 5'd16;
	localparam logic [4:0] S_DIV_WB   = 5'd17;
	localparam logic [4:0] S_FALLBACK = 5'd18;
	localparam logic [4:0] S_FIN      = 5'd19;

	// Dot product operand modes.
	localparam logic [1:0] M_DD = 2'd0;
	localparam logic [1:0] M_EE = 2'd1;
	localparam logic [1:0] M_DE = 2'd2;

	// Vertex and arc length memories.
	coord_t      mem_x [MAX_POINTS];
	coord_t      mem_y [MAX_POINTS];
	coord_t      mem_z [MAX_POINTS];
	logic [31:0] mem_c [MAX_POINTS];

	logic [4:0]    state_q, wret_q, dret_q;
	logic          closed_q;
	logic [31:0]   eps_q;
	logic [CW-1:0] count_q, i_q;
	logic [31:0]   total_q, cum_q;
	logic [AW-1:0] rd_addr_q, best_q, j_q;
	coord_t        rd_x_q, rd_y_q, rd_z_q;
	logic [31:0]   rd_c_q;
	coord_t        p_x_q, p_y_q, p_z_q;
	logic          step_q, k_q;

	// Dot product unit.
	diff_t        d_x_q, d_y_q, d_z_q, e_x_q, e_y_q, e_z_q;
	logic [1:0]   mode_q, ph_q;
	logic signed [65:0] prod_q;
	wide_t        acc_q;

	// Square root unit.
	logic [67:0]  rad_q;
	logic [37:0]  rem_q;
	logic [33:0]  root_q;
	logic [5:0]   scnt_q;

	// Scan and segment registers.
	logic [67:0]  best_d_q, dd_q, n_q;
	coord_t       cand_x_q, cand_y_q, cand_z_q, b_x_q, b_y_q, b_z_q;
	coord_t       a_x_q, a_y_q, a_z_q;
	logic [31:0]  cand_c_q, bcov_q, cova_q, covb_q;

	// Serial divider.
	logic [67:0]  dr_q;
	logic [32:0]  dq_q, dm_q;
	logic [5:0]   dcnt_q;
	logic         dph_q, dneg_q;
	logic [1:0]   didx_q;

	// Result work and output registers.
	logic [1:0]   rs_status_q, status_q;
	logic [31:0]  rs_cov_q, cov_q;
	coord_t       rs_x_q, rs_y_q, rs_z_q, ox_q, oy_q, oz_q;
	logic [9:0]   idx_q;
	logic         out_valid_q;

	logic          in_fire, vtx_we, cum_we;
	logic [31:0]   cum_wdata;
	diff_t         mul_a, mul_b, d_sel, e_sel;
	logic signed [65:0] mul_w;
	logic [37:0]   rem_sh, trial;
	logic [34:0]   sum_w;
	logic [31:0]   sat_w;
	logic [AW-1:0] last_w, j_w;
	logic          skip_w, too_few_w, best_last_w, j_last_w;
	logic [67:0]   r2_w, t_w;
	diff_t         delta_w;
	logic [31:0]   base_w, wb_w;

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid & in_ready;
	assign pready    = 1'b1;
	assign prdata    = paddr[2] ? eps_q : {31'd0, closed_q};

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign coverage      = cov_q;
	assign proj_x        = ox_q;
	assign proj_y        = oy_q;
	assign proj_z        = oz_q;
	assign nearest_index = idx_q;

	// Memory write enables.
	assign vtx_we    = in_fire && (req_type == REQ_APPEND) && (count_q < CW'(MAX_POINTS));
	assign cum_we    = (vtx_we && (count_q == '0)) || (state_q == S_APP_CUM);
	assign cum_wdata = (state_q == S_APP_CUM) ? sat_w : 32'd0;

	always_ff @(posedge clk) begin
		if (vtx_we) begin
			mem_x[count_q[AW-1:0]] <= coord_x;
			mem_y[count_q[AW-1:0]] <= coord_y;
			mem_z[count_q[AW-1:0]] <= coord_z;
		end
		if (cum_we) begin
			mem_c[count_q[AW-1:0]] <= cum_wdata;
		end
		rd_x_q <= mem_x[rd_addr_q];
		rd_y_q <= mem_y[rd_addr_q];
		rd_z_q <= mem_z[rd_addr_q];
		rd_c_q <= mem_c[rd_addr_q];
	end

	// Multiplier operand selection by axis.
	always_comb begin
		case (ph_q)
			2'd1: begin
				d_sel = d_y_q;
				e_sel = e_y_q;
			end
			2'd2: begin
				d_sel = d_z_q;
				e_sel = e_z_q;
			end
			default: begin
				d_sel = d_x_q;
				e_sel = e_x_q;
			end
		endcase
		mul_a = (mode_q == M_EE) ? e_sel : d_sel;
		mul_b = (mode_q == M_DD) ? d_sel : e_sel;
	end

	assign mul_w = mul_a * mul_b;

	// Square root step and saturating length add.
	assign rem_sh = {rem_q[35:0], rad_q[67:66]};
	assign trial  = {2'b00, root_q, 2'b01};
	assign sum_w  = {3'b000, cum_q} + {1'b0, root_q};
	assign sat_w  = (sum_w[34:32] != 3'd0) ? 32'hFFFF_FFFF : sum_w[31:0];

	// Neighbor selection around the nearest vertex.
	assign last_w = AW'(count_q - CW'(1));
	always_comb begin
		j_w    = '0;
		skip_w = 1'b0;
		if (!k_q) begin
			if (best_q == '0) begin
				j_w    = last_w;
				skip_w = !closed_q;
			end else begin
				j_w = best_q - AW'(1);
			end
		end else begin
			if (CW'(best_q) + CW'(1) >= count_q) begin
				skip_w = !closed_q;
			end else begin
				j_w = best_q + AW'(1);
			end
		end
	end

	assign too_few_w   = (count_q < CW'(2)) || (closed_q && (count_q < CW'(3)));
	assign best_last_w = (best_q == last_w);
	assign j_last_w    = (j_q == last_w);

	// Divider step terms and per-field operands.
	assign r2_w = {dr_q[66:0], 1'b0};
	assign t_w  = dr_q + n_q;
	always_comb begin
		case (didx_q)
			2'd1: begin
				delta_w = e_x_q;
				base_w  = a_x_q;
			end
			2'd2: begin
				delta_w = e_y_q;
				base_w  = a_y_q;
			end
			2'd3: begin
				delta_w = e_z_q;
				base_w  = a_z_q;
			end
			default: begin
				delta_w = {1'b0, covb_q} - {1'b0, cova_q};
				base_w  = cova_q;
			end
		endcase
		wb_w = dneg_q ? (base_w - dq_q[31:0]) : (base_w + dq_q[31:0]);
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			closed_q <= 1'b0;
			eps_q    <= EPS_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_LINE_CLOSED: closed_q <= pwdata[0];
				REG_EPSILON_SQ:  eps_q    <= pwdata;
				default:         ;
			endcase
		end
	end

	// Main sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wret_q      <= S_IDLE;
			dret_q      <= S_IDLE;
			count_q     <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
			rd_addr_q   <= '0;
			i_q         <= '0;
			step_q      <= 1'b0;
			k_q         <= 1'b0;
			ph_q        <= '0;
			mode_q      <= M_DD;
		end else begin
			if (out_valid_q && out_ready && (state_q != S_FIN)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						p_x_q <= coord_x;
						p_y_q <= coord_y;
						p_z_q <= coord_z;
						case (req_type)
							REQ_CLEAR: begin
								count_q <= '0;
								total_q <= '0;
							end
							REQ_APPEND: begin
								if (vtx_we) begin
									if (count_q == '0) begin
										total_q <= '0;
										count_q <= CW'(1);
									end else begin
										rd_addr_q <= last_w;
										step_q    <= 1'b0;
										wret_q    <= S_APP_LD;
										state_q   <= S_WAIT;
									end
								end
							end
							REQ_QUERY: state_q <= S_Q_START;
							default: ;
						endcase
					end
				end
				S_WAIT: state_q <= wret_q;
				S_DOT: begin
					prod_q <= mul_w;
					if (ph_q != 2'd0) begin
						acc_q <= acc_q + {{2{prod_q[65]}}, prod_q};
					end
					ph_q <= ph_q + 2'd1;
					if (ph_q == 2'd3) begin
						state_q <= dret_q;
					end
				end
				S_SQRT: begin
					if (rem_sh >= trial) begin
						rem_q  <= rem_sh - trial;
						root_q <= {root_q[32:0], 1'b1};
					end else begin
						rem_q  <= rem_sh;
						root_q <= {root_q[32:0], 1'b0};
					end
					rad_q  <= {rad_q[65:0], 2'b00};
					scnt_q <= scnt_q + 6'd1;
					if (scnt_q == 6'd33) begin
						state_q <= step_q ? S_APP_TOT : S_APP_CUM;
					end
				end
				// Append: length from the new point to a stored one.
				S_APP_LD: begin
					if (!step_q) begin
						cum_q <= rd_c_q;
					end
					d_x_q   <= {p_x_q[31], p_x_q} - {rd_x_q[31], rd_x_q};
					d_y_q   <= {p_y_q[31], p_y_q} - {rd_y_q[31], rd_y_q};
					d_z_q   <= {p_z_q[31], p_z_q} - {rd_z_q[31], rd_z_q};
					acc_q   <= '0;
					ph_q    <= '0;
					mode_q  <= M_DD;
					dret_q  <= S_APP_SQ;
					state_q <= S_DOT;
				end
				S_APP_SQ: begin
					rad_q   <= acc_q;
					rem_q   <= '0;
					root_q  <= '0;
					scnt_q  <= '0;
					state_q <= S_SQRT;
				end
				S_APP_CUM: begin
					cum_q     <= sat_w;
					rd_addr_q <= '0;
					step_q    <= 1'b1;
					wret_q    <= S_APP_LD;
					state_q   <= S_WAIT;
				end
				S_APP_TOT: begin
					total_q <= sat_w;
					count_q <= count_q + CW'(1);
					state_q <= S_IDLE;
				end
				// Query: nearest vertex scan.
				S_Q_START: begin
					if (too_few_w) begin
						rs_status_q <= ST_TOO_FEW;
						rs_cov_q    <= '0;
						rs_x_q      <= '0;
						rs_y_q      <= '0;
						rs_z_q      <= '0;
						state_q     <= S_FIN;
					end else begin
						i_q       <= '0;
						rd_addr_q <= '0;
						wret_q    <= S_SCAN_LD;
						state_q   <= S_WAIT;
					end
				end
				S_SCAN_LD: begin
					cand_x_q  <= rd_x_q;
					cand_y_q  <= rd_y_q;
					cand_z_q  <= rd_z_q;
					cand_c_q  <= rd_c_q;
					d_x_q     <= {rd_x_q[31], rd_x_q} - {p_x_q[31], p_x_q};
					d_y_q     <= {rd_y_q[31], rd_y_q} - {p_y_q[31], p_y_q};
					d_z_q     <= {rd_z_q[31], rd_z_q} - {p_z_q[31], p_z_q};
					rd_addr_q <= AW'(i_q + CW'(1));
					acc_q     <= '0;
					ph_q      <= '0;
					mode_q    <= M_DD;
					dret_q    <= S_SCAN_CMP;
					state_q   <= S_DOT;
				end
				S_SCAN_CMP: begin
					if ((i_q == '0) || ($unsigned(acc_q) < best_d_q)) begin
						best_d_q <= acc_q;
						best_q   <= AW'(i_q);
						b_x_q    <= cand_x_q;
						b_y_q    <= cand_y_q;
						b_z_q    <= cand_z_q;
						bcov_q   <= cand_c_q;
					end
					if (i_q + CW'(1) == count_q) begin
						k_q     <= 1'b0;
						state_q <= S_K_START;
					end else begin
						i_q     <= i_q + CW'(1);
						state_q <= S_SCAN_LD;
					end
				end
				// Query: segment towards one neighbor.
				S_K_START: begin
					if (skip_w) begin
						k_q     <= 1'b1;
						state_q <= k_q ? S_FALLBACK : S_K_START;
					end else begin
						j_q       <= j_w;
						rd_addr_q <= j_w;
						wret_q    <= S_K_LD;
						state_q   <= S_WAIT;
					end
				end
				S_K_LD: begin
					a_x_q   <= rd_x_q;
					a_y_q   <= rd_y_q;
					a_z_q   <= rd_z_q;
					cova_q  <= rd_c_q;
					e_x_q   <= {b_x_q[31], b_x_q} - {rd_x_q[31], rd_x_q};
					e_y_q   <= {b_y_q[31], b_y_q} - {rd_y_q[31], rd_y_q};
					e_z_q   <= {b_z_q[31], b_z_q} - {rd_z_q[31], rd_z_q};
					d_x_q   <= {p_x_q[31], p_x_q} - {rd_x_q[31], rd_x_q};
					d_y_q   <= {p_y_q[31], p_y_q} - {rd_y_q[31], rd_y_q};
					d_z_q   <= {p_z_q[31], p_z_q} - {rd_z_q[31], rd_z_q};
					acc_q   <= '0;
					ph_q    <= '0;
					mode_q  <= M_EE;
					dret_q  <= S_K_D;
					state_q <= S_DOT;
				end
				S_K_D: begin
					dd_q <= acc_q;
					if ($unsigned(acc_q) <= {36'd0, eps_q}) begin
						k_q     <= 1'b1;
						state_q <= k_q ? S_FALLBACK : S_K_START;
					end else begin
						acc_q   <= '0;
						ph_q    <= '0;
						mode_q  <= M_DE;
						dret_q  <= S_K_N;
						state_q <= S_DOT;
					end
				end
				S_K_N: begin
					n_q <= acc_q;
					if (acc_q[67] || ($unsigned(acc_q) > dd_q)) begin
						k_q     <= 1'b1;
						state_q <= k_q ? S_FALLBACK : S_K_START;
					end else begin
						// Closed line: the seam end takes the loop length.
						covb_q <= (closed_q && (best_q == '0) && j_last_w) ? total_q : bcov_q;
						if (closed_q && !((best_q == '0) && j_last_w) &&
								(j_q == '0) && best_last_w) begin
							cova_q <= total_q;
						end
						didx_q  <= '0;
						state_q <= S_DIV_SET;
					end
				end
				// Serial scaled division: trunc(n * |delta| / D).
				S_DIV_SET: begin
					dneg_q  <= delta_w[32];
					dm_q    <= delta_w[32] ? 33'(-delta_w) : 33'(delta_w);
					dr_q    <= '0;
					dq_q    <= '0;
					dcnt_q  <= '0;
					dph_q   <= 1'b0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (!dph_q) begin
						if (r2_w >= dd_q) begin
							dr_q <= r2_w - dd_q;
							dq_q <= {dq_q[31:0], 1'b1};
						end else begin
							dr_q <= r2_w;
							dq_q <= {dq_q[31:0], 1'b0};
						end
						dph_q <= 1'b1;
					end else begin
						if (dm_q[32]) begin
							if (t_w >= dd_q) begin
								dr_q <= t_w - dd_q;
								dq_q <= dq_q + 33'd1;
							end else begin
								dr_q <= t_w;
							end
						end
						dm_q   <= {dm_q[31:0], 1'b0};
						dph_q  <= 1'b0;
						dcnt_q <= dcnt_q + 6'd1;
						if (dcnt_q == 6'd32) begin
							state_q <= S_DIV_WB;
						end
					end
				end
				S_DIV_WB: begin
					case (didx_q)
						2'd0:    rs_cov_q <= wb_w;
						2'd1:    rs_x_q   <= wb_w;
						2'd2:    rs_y_q   <= wb_w;
						default: rs_z_q   <= wb_w;
					endcase
					if (didx_q == 2'd3) begin
						rs_status_q <= ST_PROJECTED;
						state_q     <= S_FIN;
					end else begin
						didx_q  <= didx_q + 2'd1;
						state_q <= S_DIV_SET;
					end
				end
				S_FALLBACK: begin
					rs_status_q <= ST_VERTEX;
					rs_cov_q    <= bcov_q;
					rs_x_q      <= b_x_q;
					rs_y_q      <= b_y_q;
					rs_z_q      <= b_z_q;
					state_q     <= S_FIN;
				end
				// Hand the result to the output register once it is free.
				S_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						status_q    <= rs_status_q;
						cov_q       <= rs_cov_q;
						ox_q        <= rs_x_q;
						oy_q        <= rs_y_q;
						oz_q        <= rs_z_q;
						idx_q       <= (rs_status_q == ST_TOO_FEW) ? 10'd0 : 10'(best_q);
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: rtl/palp_checker.sv
// ----------------------------------------------------------------------------
// palp_checker
// Port-level checks of the polyline arc length projection block.
// ----------------------------------------------------------------------------
`default_nettype none

`include "polyline_arc_length_projection_macros.svh"

module palp_checker
	import palp_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        pready,
	input logic        in_valid,
	input logic        in_ready,
	input logic [1:0]  req_type,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  status,
	input logic [31:0] coverage,
	input coord_t      proj_x,
	input logic [9:0]  nearest_index
);

	// A result beat stays offered until it is taken.
	`PALP_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result beat dropped")

	// A query keeps the block busy for at least the next cycle.
	`PALP_NEXT(a_query_busy, in_valid && in_ready && req_type == REQ_QUERY, !in_ready, "query not busy")

	// A too-few-points result carries zero fields.
	`PALP_IMPLY(a_too_few_zero, out_valid && status == ST_TOO_FEW, coverage == 32'd0 && proj_x == 32'sd0 && nearest_index == 10'd0, "too few result not zero")

	// The register port never inserts wait states.
	`PALP_IMPLY(a_pready, 1'b1, pready, "pready low")

endmodule

bind polyline_arc_length_projection palp_checker u_palp_checker (.*);

`default_nettype wire

FILE: tb/palp_checker.sv
// ----------------------------------------------------------------------------
// palp_scoreboard
// Watches the APB port and both streams of the polyline arc length
// projection block, predicts every query result and compares it.
// ----------------------------------------------------------------------------
`default_nettype none

module palp_scoreboard
	import palp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	input  wire logic        pready,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [1:0]  req_type,
	input  wire coord_t      coord_x,
	input  wire coord_t      coord_y,
	input  wire coord_t      coord_z,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [1:0]  status,
	input  wire logic [31:0] coverage,
	input  wire coord_t      proj_x,
	input  wire coord_t      proj_y,
	input  wire coord_t      proj_z,
	input  wire logic [9:0]  nearest_index,
	output int               errors,
	output int               pending,
	output int               checked
);

	localparam int DEPTH = 1024;

	typedef logic signed [127:0] w_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] coverage;
		coord_t      px;
		coord_t      py;
		coord_t      pz;
		logic [9:0]  idx;
	} answer_t;

	// Shadow copy of the stored line and the registers.
	coord_t      line_x [DEPTH];
	coord_t      line_y [DEPTH];
	coord_t      line_z [DEPTH];
	logic [31:0] arc_at [DEPTH];
	int          npts;
	logic [31:0] loop_len;
	logic        closed;
	logic [31:0] eps_sq;

	answer_t answers_due [$];

	assign pending = answers_due.size();

	function automatic w_t dot3(w_t ax, w_t ay, w_t az, w_t bx, w_t by, w_t bz);
		return ax * bx + ay * by + az * bz;
	endfunction

	// Floor square root of a squared length, giving Q16.16.
	function automatic logic [63:0] floor_root(w_t x);
		logic [63:0] r;
		w_t cc;
		r = 0;
		for (int b = 35; b >= 0; b--) begin
			cc = w_t'(r | (64'd1 << b));
			if (cc * cc <= x) r = r | (64'd1 << b);
		end
		return r;
	endfunction

	function automatic logic [63:0] edge_len(int i, int j);
		w_t dx, dy, dz;
		dx = w_t'(line_x[i]) - w_t'(line_x[j]);
		dy = w_t'(line_y[i]) - w_t'(line_y[j]);
		dz = w_t'(line_z[i]) - w_t'(line_z[j]);
		return floor_root(dot3(dx, dy, dz, dx, dy, dz));
	endfunction

	function automatic logic [31:0] sat_sum(logic [63:0] a, logic [63:0] b);
		logic [63:0] s;
		s = a + b;
		return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	// Truncated n*delta/d toward zero, with 0 <= n <= d.
	function automatic w_t lerp_step(w_t delta, w_t n, w_t d);
		w_t m, q;
		m = (delta < 0) ? -delta : delta;
		q = (n * m) / d;
		return (delta < 0) ? -q : q;
	endfunction

	// Result of a query against the current shadow line.
	function automatic answer_t project(coord_t qx, coord_t qy, coord_t qz);
		answer_t a;
		int best, j;
		w_t bestd, d2, dx, dy, dz, dd, nn;
		logic [31:0] cov_a, cov_b;
		bit hit;
		a = '0;
		hit = 0;
		if (npts < 2 || (closed && npts < 3)) begin
			a.status = ST_TOO_FEW;
			return a;
		end
		best = 0;
		bestd = 0;
		for (int i = 0; i < npts; i++) begin
			dx = w_t'(line_x[i]) - w_t'(qx);
			dy = w_t'(line_y[i]) - w_t'(qy);
			dz = w_t'(line_z[i]) - w_t'(qz);
			d2 = dot3(dx, dy, dz, dx, dy, dz);
			if (i == 0 || d2 < bestd) begin
				bestd = d2;
				best = i;
			end
		end
		// Previous neighbor first, then the next one.
		for (int k = 0; k < 2 && !hit; k++) begin
			j = -1;
			if (k == 0) begin
				if (best != 0) j = best - 1;
				else if (closed) j = npts - 1;
			end else begin
				if (best + 1 < npts) j = best + 1;
				else if (closed) j = 0;
			end
			if (j >= 0) begin
				dx = w_t'(line_x[best]) - w_t'(line_x[j]);
				dy = w_t'(line_y[best]) - w_t'(line_y[j]);
				dz = w_t'(line_z[best]) - w_t'(line_z[j]);
				dd = dot3(dx, dy, dz, dx, dy, dz);
				nn = dot3(w_t'(qx) - w_t'(line_x[j]), w_t'(qy) - w_t'(line_y[j]),
					w_t'(qz) - w_t'(line_z[j]), dx, dy, dz);
				if (dd > w_t'({1'b0, eps_sq}) && nn >= 0 && nn <= dd) begin
					hit = 1;
					cov_b = arc_at[best];
					cov_a = arc_at[j];
					// Closing segment of a closed line uses the loop length.
					if (closed) begin
						if (best == 0 && j == npts - 1) cov_b = loop_len;
						else if (j == 0 && best == npts - 1) cov_a = loop_len;
					end
					a.status = ST_PROJECTED;
					a.coverage = 32'(w_t'({1'b0, cov_a}) +
						lerp_step(w_t'({1'b0, cov_b}) - w_t'({1'b0, cov_a}), nn, dd));
					a.px = 32'(w_t'(line_x[j]) + lerp_step(dx, nn, dd));
					a.py = 32'(w_t'(line_y[j]) + lerp_step(dy, nn, dd));
					a.pz = 32'(w_t'(line_z[j]) + lerp_step(dz, nn, dd));
					a.idx = 10'(best);
				end
			end
		end
		if (!hit) begin
			a.status = ST_VERTEX;
			a.coverage = arc_at[best];
			a.px = line_x[best];
			a.py = line_y[best];
			a.pz = line_z[best];
			a.idx = 10'(best);
		end
		return a;
	endfunction

	// Track register writes, input beats and result beats.
	always @(posedge clk or negedge arst_n) begin
		answer_t got, want;
		if (!arst_n) begin
			npts <= 0;
			loop_len <= 0;
			closed <= 1'b0;
			eps_sq <= EPS_RESET;
			errors <= 0;
			checked <= 0;
			answers_due.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_LINE_CLOSED) closed <= pwdata[0];
				else eps_sq <= pwdata;
			end
			if (in_valid && in_ready) begin
				case (req_type)
					REQ_CLEAR: begin
						npts <= 0;
						loop_len <= 0;
					end
					REQ_APPEND: begin
						if (npts < DEPTH) begin
							line_x[npts] = coord_x;
							line_y[npts] = coord_y;
							line_z[npts] = coord_z;
							if (npts == 0) begin
								arc_at[0] = 0;
								loop_len <= 0;
							end else begin
								arc_at[npts] = sat_sum(64'(arc_at[npts - 1]),
									edge_len(npts, npts - 1));
								loop_len <= sat_sum(64'(arc_at[npts]), edge_len(npts, 0));
							end
							npts <= npts + 1;
						end
					end
					REQ_QUERY: answers_due.insert(answers_due.size(),
						project(coord_x, coord_y, coord_z));
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				got = '{status, coverage, proj_x, proj_y, proj_z, nearest_index};
				if (answers_due.size() == 0) begin
					if (errors < 10) $display("ERROR: result beat with nothing expected");
					errors <= errors + 1;
				end else begin
					want = answers_due.pop_front();
					checked <= checked + 1;
					if (got.status !== want.status || got.coverage !== want.coverage ||
							got.px !== want.px || got.py !== want.py ||
							got.pz !== want.pz || got.idx !== want.idx) begin
						if (errors < 10) begin
							$display("ERROR: result %0d mismatch", checked);
							$display("  expected st=%0d cov=%h p=(%h %h %h) idx=%0d",
								want.status, want.coverage, want.px, want.py, want.pz,
								want.idx);
							$display("  actual   st=%0d cov=%h p=(%h %h %h) idx=%0d",
								got.status, got.coverage, got.px, got.py, got.pz, got.idx);
						end
						errors <= errors + 1;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives clears, appends and queries into the polyline arc length projection
// block under several register settings, with random gaps on both streams
// and one long receiver stall; the checker predicts and compares results.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	import palp_pkg::*;

	localparam int LIMIT    = 3000000;
	localparam int QUIET_LO = 40000;
	localparam int QUIET_HI = 90000;
	localparam int HOLD_LEN = 3000;
	localparam int SETTLE   = 300;
	localparam int NUM_RAND = 540;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid, in_ready;
	logic [1:0]  req_type;
	coord_t      coord_x, coord_y, coord_z;
	logic        out_valid, out_ready;
	logic [1:0]  status;
	logic [31:0] coverage;
	coord_t      proj_x, proj_y, proj_z;
	logic [9:0]  nearest_index;

	int errors, pending, checked;
	int cyc;
	int beats_sent, queries_sent, setups;
	bit hold_go, hold_done;
	coord_t pts_x [$], pts_y [$], pts_z [$];

	polyline_arc_length_projection uut (.*);

	palp_scoreboard chk (.*);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Cycle count and run limit.
	initial cyc = 0;
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc > LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic bit idle_now();
		return (cyc < QUIET_LO || cyc >= QUIET_HI) && $urandom_range(0, 99) < 11;
	endfunction

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin
		out_ready <= 1'b0;
		hold_done = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_go && !hold_done) begin
				out_ready <= 1'b0;
				hold_done = 1;
				repeat (HOLD_LEN) @(posedge clk);
			end
			out_ready <= !idle_now();
		end
	end

	task automatic reg_write(logic idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// One input beat; valid stays high afterwards unless a gap follows.
	task automatic send_beat(logic [1:0] rq, coord_t x, coord_t y, coord_t z);
		int gap;
		if (idle_now()) begin
			gap = $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rq;
		coord_x <= x;
		coord_y <= y;
		coord_z <= z;
		do @(posedge clk); while (!in_ready);
		if (rq != 2'd3) beats_sent++;
		if (rq == REQ_QUERY) queries_sent++;
		if (rq == REQ_APPEND) begin
			pts_x.insert(pts_x.size(), x);
			pts_y.insert(pts_y.size(), y);
			pts_z.insert(pts_z.size(), z);
		end
		if (rq == REQ_CLEAR) begin
			pts_x.delete();
			pts_y.delete();
			pts_z.delete();
		end
	endtask

	// Wait until the block has drained, before a register write.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_line(logic cl, logic [31:0] eps);
		drain();
		reg_write(REG_LINE_CLOSED, {31'd0, cl});
		reg_write(REG_EPSILON_SQ, eps);
		setups++;
	endtask

	function automatic coord_t near_val(coord_t c, int spread);
		return coord_t'(c + $signed($urandom_range(0, 2 * spread)) - spread);
	endfunction

	initial begin
		int n, nq, base_x, base_y, base_z, pick;
		logic [31:0] eps;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		req_type <= REQ_CLEAR;
		coord_x <= '0;
		coord_y <= '0;
		coord_z <= '0;
		hold_go = 0;
		beats_sent = 0;
		queries_sent = 0;
		setups = 1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty and single-point line, open segment ends.
		send_beat(REQ_QUERY, 0, 0, 0);
		send_beat(REQ_APPEND, 0, 0, 0);
		send_beat(REQ_QUERY, 32'h0001_0000, 0, 0);
		send_beat(REQ_APPEND, 32'h000A_0000, 0, 0);
		send_beat(REQ_QUERY, 32'h0003_0000, 32'h0001_0000, 0);
		send_beat(REQ_QUERY, 32'h0014_0000, 0, 0);
		send_beat(REQ_QUERY, 32'hFFFB_0000, 0, 0);
		send_beat(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		// Closed line: too few with two points, then the wrap segments.
		set_line(1'b1, EPS_RESET);
		send_beat(REQ_QUERY, 0, 0, 0);
		send_beat(REQ_APPEND, 32'h000A_0000, 32'h000A_0000, 0);
		send_beat(REQ_QUERY, 0, 32'h0005_0000, 0);
		send_beat(REQ_QUERY, 32'h000A_0000, 32'h0006_0000, 0);
		send_beat(REQ_QUERY, 32'h0005_0000, 32'h0005_8000, 0);
		// Tiny segments against the largest and smallest thresholds.
		set_line(1'b0, 32'hFFFF_FFFF);
		send_beat(REQ_CLEAR, 0, 0, 0);
		send_beat(REQ_APPEND, 0, 0, 0);
		send_beat(REQ_APPEND, 32'h0000_0100, 0, 0);
		send_beat(REQ_APPEND, 32'h0000_0100, 32'h0000_0100, 0);
		send_beat(REQ_QUERY, 32'h0000_0080, 1, 0);
		set_line(1'b1, 32'd0);
		send_beat(REQ_QUERY, 32'h0000_0080, 1, 0);
		// Coordinate extremes and saturated arc lengths.
		send_beat(REQ_CLEAR, 0, 0, 0);
		send_beat(REQ_APPEND, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_beat(REQ_APPEND, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_beat(REQ_APPEND, 0, 32'h7FFF_FFFF, 32'h8000_0000);
		send_beat(REQ_QUERY, 32'h7FFF_FFFF, 32'h8000_0000, 0);
		send_beat(REQ_QUERY, 32'h1000_0000, 32'h1000_0000, 32'h1000_0000);

		// Random line setups with queries mostly close to the line.
		while (beats_sent < NUM_RAND) begin
			case ($urandom_range(0, 4))
				0: eps = 32'd0;
				1: eps = 32'hFFFF_FFFF;
				2: eps = $urandom;
				default: eps = $urandom_range(0, 1 << 20);
			endcase
			set_line($urandom_range(0, 1), eps);
			send_beat(REQ_CLEAR, $urandom, $urandom, $urandom);
			base_x = $signed($urandom_range(0, 1 << 29)) - (1 << 28);
			base_y = $signed($urandom_range(0, 1 << 29)) - (1 << 28);
			base_z = $signed($urandom_range(0, 1 << 29)) - (1 << 28);
			if ($urandom_range(0, 11) == 0) n = $urandom_range(0, 2);
			else if ($urandom_range(0, 9) == 0) n = $urandom_range(20, 60);
			else n = $urandom_range(3, 10);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 19) == 0)
					send_beat(REQ_APPEND, $urandom, $urandom, $urandom);
				else
					send_beat(REQ_APPEND, near_val(base_x, 1 << 21),
						near_val(base_y, 1 << 21), near_val(base_z, 1 << 21));
			end
			if (setups == 4) hold_go = 1;
			nq = $urandom_range(4, 14);
			for (int i = 0; i < nq; i++) begin
				pick = $urandom_range(0, 99);
				if (pick < 5)
					send_beat(2'd3, $urandom, $urandom, $urandom);
				else if (pick < 8)
					send_beat(REQ_APPEND, near_val(base_x, 1 << 21),
						near_val(base_y, 1 << 21), near_val(base_z, 1 << 21));
				else if (pick < 18 || pts_x.size() == 0)
					send_beat(REQ_QUERY, $urandom, $urandom, $urandom);
				else begin
					n = $urandom_range(0, pts_x.size() - 1);
					send_beat(REQ_QUERY, near_val(pts_x[n], 1 << 19),
						near_val(pts_y[n], 1 << 19), near_val(pts_z[n], 1 << 19));
				end
			end
		end

		drain();
		$display("Summary: %0d beats (%0d queries) over %0d register setups,",
			beats_sent, queries_sent, setups);
		$display("  %0d results compared, including a long output stall.",
			checked);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

`default_nettype wire
